// File: rtl/tfv_pkg.sv
// Shared types, codes and constants of the table field validator.
package tfv_pkg;

    localparam logic [3:0] TYPE_NONE  = 4'd0;
    localparam logic [3:0] TYPE_CHAR  = 4'd1;
    localparam logic [3:0] TYPE_INT   = 4'd2;
    localparam logic [3:0] TYPE_REAL  = 4'd3;
    localparam logic [3:0] TYPE_ALPHA = 4'd4;
    localparam logic [3:0] TYPE_UPPER = 4'd5;
    localparam logic [3:0] TYPE_LOWER = 4'd6;
    localparam logic [3:0] TYPE_DIGIT = 4'd7;
    localparam logic [3:0] TYPE_ALNUM = 4'd8;

    localparam logic [2:0] RSN_OK     = 3'd0;
    localparam logic [2:0] RSN_SYNTAX = 3'd1;
    localparam logic [2:0] RSN_BELOW  = 3'd2;
    localparam logic [2:0] RSN_ABOVE  = 3'd3;
    localparam logic [2:0] RSN_CLASS  = 3'd4;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_TYPE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_ENABLE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_ENABLE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_VALUE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VALUE   = 3'd4;

    localparam logic [2:0] PHASE_START = 3'd0;
    localparam logic [2:0] PHASE_NUM   = 3'd1;
    localparam logic [2:0] PHASE_FAIL  = 3'd7;
    localparam int         REAL_LEN    = 7;

    localparam logic [31:0] MAG_CAP = 32'h8000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        KIND_SIGN,
        KIND_DIGIT,
        KIND_DOT,
        KIND_EXP
    } kind_t;

    typedef struct packed {
        logic [3:0]        column_type;
        logic              min_enable;
        logic              max_enable;
        logic signed [31:0] min_value;
        logic signed [31:0] max_value;
    } cfg_t;

    typedef struct packed {
        logic       is_sign;
        logic       is_minus;
        logic       is_digit;
        logic       is_dot;
        logic       is_exp;
        logic       is_upper;
        logic       is_lower;
        logic [3:0] digit;
        logic       last;
    } char_t;

    typedef struct packed {
        logic               field_ok;
        logic [2:0]         reason;
        logic signed [31:0] int_value;
    } result_t;

    // real grammar: sign, digits, dot, digits, exponent letter, sign, digits
    function automatic kind_t real_kind(input logic [2:0] idx);
        kind_t k;
        unique case (idx)
            3'd0:    k = KIND_SIGN;
            3'd1:    k = KIND_DIGIT;
            3'd2:    k = KIND_DOT;
            3'd3:    k = KIND_DIGIT;
            3'd4:    k = KIND_EXP;
            3'd5:    k = KIND_SIGN;
            default: k = KIND_DIGIT;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/table_field_validator_unit.sv
// Table field validator top level: config registers, queues, front and back ends.
// A verdict passes the input queue, the back end's final register and the result queue.
// Throughput: one character word per cycle, unless a last word waits for the result queue.
// A full result queue stalls the back end at a last word while a verdict waits; the input
// queue then fills and raises full. Reset (rst_n low, asynchronous) empties both queues,
// clears the parse state and zeroes every configuration register.
module table_field_validator_unit #(
    parameter int IN_DEPTH  = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [7:0]                       field_char,
    input  logic                             last_char,
    output logic                             empty,
    input  logic                             pop,
    output logic                             field_ok,
    output logic [2:0]                       reason,
    output logic signed [31:0]               int_value,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tfv_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tfv_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int CHAR_W = $bits(tfv_pkg::char_t);
    localparam int RES_W  = $bits(tfv_pkg::result_t);

    tfv_pkg::cfg_t    cfg_reg, cfg_next;
    tfv_pkg::char_t   front_item;
    tfv_pkg::char_t   mid_item;
    tfv_pkg::result_t back_res;
    tfv_pkg::result_t out_word;
    logic [CHAR_W-1:0] mid_rdata;
    logic [RES_W-1:0]  out_rdata;
    logic              mid_empty;
    logic              mid_pop;
    logic              out_full;
    logic              out_push;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tfv_pkg::REG_COLUMN_TYPE: cfg_next.column_type = cfg_data[3:0];
                tfv_pkg::REG_MIN_ENABLE:  cfg_next.min_enable  = cfg_data[0];
                tfv_pkg::REG_MAX_ENABLE:  cfg_next.max_enable  = cfg_data[0];
                tfv_pkg::REG_MIN_VALUE:   cfg_next.min_value   = cfg_data;
                tfv_pkg::REG_MAX_VALUE:   cfg_next.max_value   = cfg_data;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tfv_front u_front (
        .field_char (field_char),
        .last_char  (last_char),
        .item       (front_item)
    );

    tfv_fifo #(
        .DEPTH (IN_DEPTH),
        .WIDTH (CHAR_W)
    ) u_in_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_item),
        .full  (full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign mid_item = tfv_pkg::char_t'(mid_rdata);

    tfv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .mid_empty (mid_empty),
        .mid_item  (mid_item),
        .mid_pop   (mid_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_res   (back_res)
    );

    tfv_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (RES_W)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (back_res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

    assign out_word  = tfv_pkg::result_t'(out_rdata);
    assign field_ok  = out_word.field_ok;
    assign reason    = out_word.reason;
    assign int_value = out_word.int_value;

endmodule

// File: rtl/tfv_fifo.sv
// Small first-word-fall-through queue of packed words.
module tfv_fifo #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: rtl/tfv_front.sv
// Front end: classifies each incoming character into its grammar and class flags.
module tfv_front (
    input  logic [7:0]     field_char,
    input  logic           last_char,
    output tfv_pkg::char_t item
);

    always_comb
    begin
        item          = '0;
        item.is_sign  = (field_char == 8'h2B) || (field_char == 8'h2D);
        item.is_minus = (field_char == 8'h2D);
        item.is_digit = (field_char >= 8'h30) && (field_char <= 8'h39);
        item.is_dot   = (field_char == 8'h2E);
        item.is_exp   = (field_char == 8'h64) || (field_char == 8'h44)
                     || (field_char == 8'h65) || (field_char == 8'h45);
        item.is_upper = (field_char >= 8'h41) && (field_char <= 8'h5A);
        item.is_lower = (field_char >= 8'h61) && (field_char <= 8'h7A);
        item.digit    = field_char[3:0];
        item.last     = last_char;
    end

endmodule

// File: rtl/tfv_back.sv
// Back end: per-field parse state, accumulation and end-of-field verdict.
module tfv_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tfv_pkg::cfg_t   cfg,
    input  logic            mid_empty,
    input  tfv_pkg::char_t  mid_item,
    output logic            mid_pop,
    input  logic            out_full,
    output logic            out_push,
    output tfv_pkg::result_t out_res
);

    typedef struct packed {
        logic [2:0]  phase;
        logic [31:0] accum;
        logic        negative;
        logic        class_fail;
    } snap_t;

    logic [2:0]  phase_reg;
    logic [31:0] accum_reg;
    logic        negative_reg;
    logic        class_fail_reg;
    logic        fin_valid_reg, fin_valid_next;
    snap_t       fin_reg;
    snap_t       upd;

    logic          fin_free;
    logic [2:0]    int_phase;
    logic [2:0]    real_phase;
    logic          real_found;
    tfv_pkg::kind_t kind;
    logic          in_class;
    logic [35:0]   prod;
    logic [31:0]   capped;
    logic [32:0]   mag;
    logic signed [32:0] value;
    logic signed [32:0] min_ext;
    logic signed [32:0] max_ext;

    function automatic logic kind_hit(input tfv_pkg::kind_t k, input tfv_pkg::char_t c);
        logic hit;
        unique case (k)
            tfv_pkg::KIND_SIGN:  hit = c.is_sign;
            tfv_pkg::KIND_DIGIT: hit = c.is_digit;
            tfv_pkg::KIND_DOT:   hit = c.is_dot;
            default:             hit = c.is_exp;
        endcase
        return hit;
    endfunction

    assign fin_free = !fin_valid_reg || !out_full;
    assign mid_pop  = !mid_empty && (!mid_item.last || fin_free);
    assign out_push = fin_valid_reg && !out_full;

    always_comb
    begin
        unique case (phase_reg)
            tfv_pkg::PHASE_START:
                int_phase = (mid_item.is_sign || mid_item.is_digit)
                          ? tfv_pkg::PHASE_NUM : tfv_pkg::PHASE_FAIL;
            tfv_pkg::PHASE_NUM:
                int_phase = mid_item.is_digit ? tfv_pkg::PHASE_NUM : tfv_pkg::PHASE_FAIL;
            default:
                int_phase = tfv_pkg::PHASE_FAIL;
        endcase
    end

    always_comb
    begin
        real_phase = tfv_pkg::PHASE_FAIL;
        real_found = 1'b0;
        kind       = tfv_pkg::KIND_SIGN;
        for (int e = 0; e < tfv_pkg::REAL_LEN; e++)
        begin
            kind = tfv_pkg::real_kind(3'(e));
            if (!real_found && (3'(e) >= phase_reg) && kind_hit(kind, mid_item))
            begin
                real_found = 1'b1;
                real_phase = (kind == tfv_pkg::KIND_DIGIT) ? 3'(e) : 3'(e + 1);
            end
        end
    end

    always_comb
    begin
        unique case (cfg.column_type)
            tfv_pkg::TYPE_ALPHA: in_class = mid_item.is_upper || mid_item.is_lower;
            tfv_pkg::TYPE_UPPER: in_class = mid_item.is_upper;
            tfv_pkg::TYPE_LOWER: in_class = mid_item.is_lower;
            tfv_pkg::TYPE_DIGIT: in_class = mid_item.is_digit;
            tfv_pkg::TYPE_ALNUM: in_class = mid_item.is_upper || mid_item.is_lower
                                         || mid_item.is_digit;
            default:             in_class = 1'b1;
        endcase
    end

    // accum * 10 + digit, capped at 2^31
    assign prod   = ({4'b0, accum_reg} << 3) + ({4'b0, accum_reg} << 1)
                  + {32'b0, mid_item.digit};
    assign capped = (prod > {4'b0, tfv_pkg::MAG_CAP}) ? tfv_pkg::MAG_CAP : prod[31:0];

    always_comb
    begin
        upd.phase      = phase_reg;
        upd.accum      = accum_reg;
        upd.negative   = negative_reg;
        upd.class_fail = class_fail_reg || !in_class;
        if (cfg.column_type == tfv_pkg::TYPE_INT)
        begin
            upd.phase = int_phase;
            if (int_phase == tfv_pkg::PHASE_NUM && mid_item.is_digit)
            begin
                upd.accum = capped;
            end
            else if (int_phase == tfv_pkg::PHASE_NUM && mid_item.is_minus)
            begin
                upd.negative = 1'b1;
            end
        end
        else if (cfg.column_type == tfv_pkg::TYPE_REAL)
        begin
            upd.phase = real_phase;
        end
    end

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (mid_pop && mid_item.last)
        begin
            fin_valid_next = 1'b1;
        end
        else if (out_push)
        begin
            fin_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tfv_pkg::PHASE_START;
            accum_reg      <= '0;
            negative_reg   <= 1'b0;
            class_fail_reg <= 1'b0;
            fin_valid_reg  <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            if (mid_pop)
            begin
                if (mid_item.last)
                begin
                    phase_reg      <= tfv_pkg::PHASE_START;
                    accum_reg      <= '0;
                    negative_reg   <= 1'b0;
                    class_fail_reg <= 1'b0;
                end
                else
                begin
                    phase_reg      <= upd.phase;
                    accum_reg      <= upd.accum;
                    negative_reg   <= upd.negative;
                    class_fail_reg <= upd.class_fail;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_pop && mid_item.last)
        begin
            fin_reg <= upd;
        end
    end

    // verdict stage
    assign mag     = {1'b0, fin_reg.accum};
    assign value   = fin_reg.negative ? -$signed(mag)
                   : (fin_reg.accum[31] ? $signed({1'b0, tfv_pkg::POS_MAX}) : $signed(mag));
    assign min_ext = {cfg.min_value[31], cfg.min_value};
    assign max_ext = {cfg.max_value[31], cfg.max_value};

    always_comb
    begin
        out_res.field_ok  = 1'b1;
        out_res.reason    = tfv_pkg::RSN_OK;
        out_res.int_value = '0;
        if (cfg.column_type == tfv_pkg::TYPE_INT)
        begin
            if (fin_reg.phase > tfv_pkg::PHASE_NUM)
            begin
                out_res.field_ok = 1'b0;
                out_res.reason   = tfv_pkg::RSN_SYNTAX;
            end
            else
            begin
                out_res.int_value = value[31:0];
                if (cfg.min_enable && (value < min_ext))
                begin
                    out_res.field_ok = 1'b0;
                    out_res.reason   = tfv_pkg::RSN_BELOW;
                end
                else if (cfg.max_enable && (value > max_ext))
                begin
                    out_res.field_ok = 1'b0;
                    out_res.reason   = tfv_pkg::RSN_ABOVE;
                end
            end
        end
        else if (cfg.column_type == tfv_pkg::TYPE_REAL)
        begin
            if (fin_reg.phase == tfv_pkg::PHASE_FAIL)
            begin
                out_res.field_ok = 1'b0;
                out_res.reason   = tfv_pkg::RSN_SYNTAX;
            end
        end
        else if ((cfg.column_type >= tfv_pkg::TYPE_ALPHA)
              && (cfg.column_type <= tfv_pkg::TYPE_ALNUM))
        begin
            if (fin_reg.class_fail)
            begin
                out_res.field_ok = 1'b0;
                out_res.reason   = tfv_pkg::RSN_CLASS;
            end
        end
    end

endmodule

// File: test/field_verdict_checker.sv
`timescale 1ns / 100ps
// Checker: predicts the verdict of every field the validator accepts and compares it.
module field_verdict_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  logic                             full,
    input  logic [7:0]                       field_char,
    input  logic                             last_char,
    input  logic                             empty,
    input  logic                             pop,
    input  logic                             field_ok,
    input  logic [2:0]                       reason,
    input  logic signed [31:0]               int_value,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [tfv_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tfv_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int                               verdict_errors,
    output int                               verdicts_pending
);
    import tfv_pkg::*;

    logic [3:0]         col_type;
    logic               min_on;
    logic               max_on;
    logic signed [31:0] min_lim;
    logic signed [31:0] max_lim;
    logic [2:0]         phase;
    logic [31:0]        magnitude;
    logic               minus;
    logic               class_bad;
    result_t            verdicts_due[$];
    result_t            want;

    initial
    begin
        verdict_errors = 0;
        verdicts_pending = 0;
    end

    function automatic kind_t grammar_kind(input logic real_col, input int idx);
        if (!real_col)
            return (idx == 0) ? KIND_SIGN : KIND_DIGIT;
        case (idx)
            0, 5:    return KIND_SIGN;
            2:       return KIND_DOT;
            4:       return KIND_EXP;
            default: return KIND_DIGIT;
        endcase
    endfunction

    function automatic logic fits_kind(input kind_t k, input logic [7:0] c);
        case (k)
            KIND_SIGN:  return c == "+" || c == "-";
            KIND_DIGIT: return c >= "0" && c <= "9";
            KIND_DOT:   return c == ".";
            default:    return c == "d" || c == "D" || c == "e" || c == "E";
        endcase
    endfunction

    // greedy match, no backtracking: first element at or after p that fits
    function automatic logic [2:0] next_phase(input logic [2:0] p, input logic [7:0] c,
                                              input logic real_col);
        kind_t      k;
        int         n;
        int         e;
        logic       found;
        logic [2:0] nxt;
        n = real_col ? REAL_LEN : 2;
        found = 1'b0;
        nxt = PHASE_FAIL;
        for (e = p; e < n; e++)
        begin
            k = grammar_kind(real_col, e);
            if (!found && fits_kind(k, c))
            begin
                nxt = (k == KIND_DIGIT) ? e[2:0] : e[2:0] + 3'd1;
                found = 1'b1;
            end
        end
        return nxt;
    endfunction

    function automatic logic in_class(input logic [3:0] t, input logic [7:0] c);
        logic up;
        logic lo;
        logic dg;
        up = c >= "A" && c <= "Z";
        lo = c >= "a" && c <= "z";
        dg = c >= "0" && c <= "9";
        case (t)
            TYPE_ALPHA: return up || lo;
            TYPE_UPPER: return up;
            TYPE_LOWER: return lo;
            TYPE_DIGIT: return dg;
            TYPE_ALNUM: return up || lo || dg;
            default:    return 1'b1;
        endcase
    endfunction

    task automatic predict_word(input logic [7:0] c, input logic lst);
        logic [2:0]  nxt;
        logic [63:0] wide;
        longint      v;
        result_t     r;
        if (col_type == TYPE_INT)
        begin
            nxt = next_phase(phase, c, 1'b0);
            if (nxt == PHASE_NUM && c >= "0" && c <= "9")
            begin
                wide = magnitude * 64'd10 + c - 64'd48;
                magnitude = (wide > {32'd0, MAG_CAP}) ? MAG_CAP : wide[31:0];
            end
            else if (nxt == PHASE_NUM && c == "-")
                minus = 1'b1;
            phase = nxt;
        end
        else if (col_type == TYPE_REAL)
            phase = next_phase(phase, c, 1'b1);
        if (!in_class(col_type, c))
            class_bad = 1'b1;
        if (lst)
        begin
            r.field_ok = 1'b1;
            r.reason = RSN_OK;
            r.int_value = '0;
            if (col_type == TYPE_INT)
            begin
                if (phase > PHASE_NUM)
                begin
                    r.field_ok = 1'b0;
                    r.reason = RSN_SYNTAX;
                end
                else
                begin
                    v = longint'({32'd0, magnitude});
                    if (minus)
                        v = -v;
                    else if (magnitude >= MAG_CAP)
                        v = longint'({32'd0, POS_MAX});
                    r.int_value = v[31:0];
                    if (min_on && v < min_lim)
                    begin
                        r.field_ok = 1'b0;
                        r.reason = RSN_BELOW;
                    end
                    else if (max_on && v > max_lim)
                    begin
                        r.field_ok = 1'b0;
                        r.reason = RSN_ABOVE;
                    end
                end
            end
            else if (col_type == TYPE_REAL)
            begin
                if (phase == PHASE_FAIL)
                begin
                    r.field_ok = 1'b0;
                    r.reason = RSN_SYNTAX;
                end
            end
            else if (col_type >= TYPE_ALPHA && col_type <= TYPE_ALNUM && class_bad)
            begin
                r.field_ok = 1'b0;
                r.reason = RSN_CLASS;
            end
            verdicts_due.push_back(r);
            phase = PHASE_START;
            magnitude = '0;
            minus = 1'b0;
            class_bad = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_type = TYPE_NONE;
            min_on = 1'b0;
            max_on = 1'b0;
            min_lim = '0;
            max_lim = '0;
            phase = PHASE_START;
            magnitude = '0;
            minus = 1'b0;
            class_bad = 1'b0;
            verdicts_due.delete();
            verdicts_pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_COLUMN_TYPE: col_type = cfg_data[3:0];
                    REG_MIN_ENABLE:  min_on = cfg_data[0];
                    REG_MAX_ENABLE:  max_on = cfg_data[0];
                    REG_MIN_VALUE:   min_lim = cfg_data;
                    REG_MAX_VALUE:   max_lim = cfg_data;
                    default:         ;
                endcase
            end
            if (pop && !empty)
            begin
                if (verdicts_due.size() == 0)
                begin
                    $error("verdict word popped with none predicted");
                    verdict_errors++;
                end
                else
                begin
                    want = verdicts_due.pop_front();
                    if (field_ok !== want.field_ok)
                    begin
                        $error("field_ok: expected %0d, got %0d", want.field_ok, field_ok);
                        verdict_errors++;
                    end
                    if (reason !== want.reason)
                    begin
                        $error("reason: expected %0d, got %0d", want.reason, reason);
                        verdict_errors++;
                    end
                    if (int_value !== want.int_value)
                    begin
                        $error("int_value: expected %0d, got %0d",
                               $signed(want.int_value), int_value);
                        verdict_errors++;
                    end
                end
            end
            if (push && !full)
                predict_word(field_char, last_char);
            verdicts_pending = verdicts_due.size();
        end
    end

endmodule

// File: test/table_field_validator_unit_tb.sv
`timescale 1ns / 100ps
// Testbench top: drives fields and register writes into the validator and gives the verdict.
module table_field_validator_unit_tb;
    import tfv_pkg::*;

    localparam int PERIOD      = 4;
    localparam int SETTLE      = 8;
    localparam int LONG_STALL  = 80;
    localparam int TOTAL_WORDS = 1775;
    localparam int CALM_WORDS  = 300;
    localparam int LIMIT_NS    = 2_000_000;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    push;
    logic                    full;
    logic [7:0]              field_char;
    logic                    last_char;
    logic                    empty;
    logic                    pop;
    logic                    field_ok;
    logic [2:0]              reason;
    logic signed [31:0]      int_value;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    int         verdict_errors;
    int         verdicts_pending;
    int         idle_pct = 0;
    int         stall_asks = 0;
    int         stalls_done = 0;
    int         words_sent = 0;
    logic [7:0] fbuf[$];

    table_field_validator_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .field_char (field_char),
        .last_char  (last_char),
        .empty      (empty),
        .pop        (pop),
        .field_ok   (field_ok),
        .reason     (reason),
        .int_value  (int_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    field_verdict_checker verdict_chk (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .field_char       (field_char),
        .last_char        (last_char),
        .empty            (empty),
        .pop              (pop),
        .field_ok         (field_ok),
        .reason           (reason),
        .int_value        (int_value),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .verdict_errors   (verdict_errors),
        .verdicts_pending (verdicts_pending)
    );

    always #(PERIOD / 2) clk = ~clk;

    initial
    begin
        #(LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    // result side: random pop bursts, plus one long hold when asked
    initial
    begin
        int idle_left;
        idle_left = 0;
        pop <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (stalls_done < stall_asks)
            begin
                pop <= 1'b0;
                repeat (LONG_STALL) @(negedge clk);
                stalls_done++;
            end
            else if (idle_left > 0)
            begin
                pop <= 1'b0;
                idle_left--;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                pop <= 1'b0;
                idle_left = $urandom_range(0, 8);
            end
            else
                pop <= 1'b1;
        end
    end

    task automatic put_char(input logic [7:0] c, input logic lst);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
        push <= 1'b1;
        field_char <= c;
        last_char <= lst;
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_buf();
        int i;
        for (i = 0; i < fbuf.size(); i++)
            put_char(fbuf[i], i == fbuf.size() - 1);
    endtask

    task automatic send_text(input string s);
        int i;
        fbuf.delete();
        for (i = 0; i < s.len(); i++)
            fbuf.push_back(s[i]);
        send_buf();
    endtask

    task automatic drain();
        push <= 1'b0;
        while (verdicts_pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_config(input logic [3:0] t, input logic mn, input logic mx,
                              input logic [31:0] lo, input logic [31:0] hi);
        drain();
        write_reg(REG_COLUMN_TYPE, {28'd0, t});
        write_reg(REG_MIN_ENABLE, {31'd0, mn});
        write_reg(REG_MAX_ENABLE, {31'd0, mx});
        write_reg(REG_MIN_VALUE, lo);
        write_reg(REG_MAX_VALUE, hi);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] sign_char();
        return $urandom_range(0, 1) ? "+" : "-";
    endfunction

    function automatic logic [7:0] class_char(input logic [3:0] t);
        case (t)
            TYPE_UPPER: return 8'("A" + $urandom_range(0, 25));
            TYPE_LOWER: return 8'("a" + $urandom_range(0, 25));
            TYPE_DIGIT: return 8'("0" + $urandom_range(0, 9));
            TYPE_ALPHA: return $urandom_range(0, 1) ? 8'("A" + $urandom_range(0, 25))
                                                     : 8'("a" + $urandom_range(0, 25));
            TYPE_ALNUM:
                case ($urandom_range(0, 2))
                    0:       return 8'("A" + $urandom_range(0, 25));
                    1:       return 8'("a" + $urandom_range(0, 25));
                    default: return 8'("0" + $urandom_range(0, 9));
                endcase
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'd0;
            5:       return $urandom;
            default: return 32'($urandom_range(0, 2000)) - 32'd1000;
        endcase
    endfunction

    function automatic logic [3:0] pick_type();
        int r;
        r = $urandom_range(0, 19);
        if (r < 6 || r > 17)
            return TYPE_INT;
        if (r < 10)
            return TYPE_REAL;
        if (r < 15)
            return 4'(TYPE_ALPHA + (r - 10));
        if (r == 15)
            return TYPE_NONE;
        if (r == 16)
            return TYPE_CHAR;
        return 4'($urandom_range(9, 15));
    endfunction

    task automatic add_digits(input int n);
        repeat (n) fbuf.push_back(8'("0" + $urandom_range(0, 9)));
    endtask

    task automatic add_noise(input int n);
        repeat (n) fbuf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            fbuf.push_back(s[i]);
    endtask

    task automatic build_field(input logic [3:0] t);
        string exps;
        string junk;
        exps = "dDeE";
        junk = "+-.eE5x";
        fbuf.delete();
        if (t == TYPE_INT)
        begin
            case ($urandom_range(0, 9))
                0: fbuf.push_back(sign_char());
                1:
                begin
                    if ($urandom_range(0, 1))
                        fbuf.push_back(sign_char());
                    case ($urandom_range(0, 4))
                        0:       add_text("2147483647");
                        1:       add_text("2147483648");
                        2:       add_text("2147483649");
                        3:       add_text("99999999999");
                        default: add_text("0000000000002147483647");
                    endcase
                end
                2:
                begin
                    if ($urandom_range(0, 1))
                        fbuf.push_back(sign_char());
                    add_digits($urandom_range(10, 13));
                end
                3: add_noise($urandom_range(1, 6));
                4:
                begin
                    add_digits($urandom_range(1, 3));
                    fbuf.push_back(junk[$urandom_range(0, 2)]);
                    add_digits($urandom_range(0, 2));
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        fbuf.push_back(sign_char());
                    add_digits($urandom_range(1, 5));
                end
            endcase
        end
        else if (t == TYPE_REAL)
        begin
            if ($urandom_range(0, 5) == 0)
                add_noise($urandom_range(1, 6));
            else
            begin
                if ($urandom_range(0, 1))
                    fbuf.push_back(sign_char());
                if ($urandom_range(0, 1))
                    add_digits($urandom_range(1, 3));
                if ($urandom_range(0, 1))
                    fbuf.push_back(".");
                if ($urandom_range(0, 1))
                    add_digits($urandom_range(1, 3));
                if ($urandom_range(0, 1))
                    fbuf.push_back(exps[$urandom_range(0, 3)]);
                if ($urandom_range(0, 1))
                    fbuf.push_back(sign_char());
                if ($urandom_range(0, 1))
                    add_digits($urandom_range(1, 3));
                if (fbuf.size() == 0)
                    add_digits(1);
                if ($urandom_range(0, 7) == 0)
                    fbuf.push_back(junk[$urandom_range(0, 6)]);
            end
        end
        else if (t >= TYPE_ALPHA && t <= TYPE_ALNUM)
        begin
            repeat ($urandom_range(1, 8))
                fbuf.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                            : class_char(t));
        end
        else
            add_noise($urandom_range(1, 6));
    endtask

    initial
    begin
        int         round;
        logic [3:0] t;
        rst_n <= 1'b0;
        push <= 1'b0;
        field_char <= '0;
        last_char <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        put_char(8'h00, 1'b1);
        set_config(TYPE_CHAR, 1'b0, 1'b0, 32'd0, 32'd0);
        put_char(8'hFF, 1'b1);
        set_config(TYPE_ALPHA, 1'b0, 1'b0, 32'd0, 32'd0);
        put_char("5", 1'b1);
        set_config(TYPE_UPPER, 1'b0, 1'b0, 32'd0, 32'd0);
        put_char("a", 1'b1);
        set_config(TYPE_LOWER, 1'b0, 1'b0, 32'd0, 32'd0);
        put_char("z", 1'b1);
        set_config(TYPE_DIGIT, 1'b0, 1'b0, 32'd0, 32'd0);
        put_char(8'h80, 1'b1);
        set_config(TYPE_ALNUM, 1'b0, 1'b0, 32'd0, 32'd0);
        send_text("Z9");
        set_config(4'd15, 1'b1, 1'b1, 32'd0, 32'd0);
        put_char("?", 1'b1);
        set_config(TYPE_REAL, 1'b0, 1'b0, 32'd0, 32'd0);
        send_text(".");
        send_text("e");
        send_text("1+5");
        put_char(8'hFF, 1'b1);
        set_config(TYPE_INT, 1'b1, 1'b1, -32'sd5, 32'sd7);
        send_text("-9");
        send_text("8");
        send_text("+");
        send_text("-");
        send_text("1-");
        // type switch with a field half parsed
        set_config(TYPE_REAL, 1'b0, 1'b0, 32'd0, 32'd0);
        put_char("1", 1'b0);
        put_char(".", 1'b0);
        set_config(TYPE_INT, 1'b0, 1'b0, 32'd0, 32'd0);
        put_char("5", 1'b1);

        round = 0;
        while (words_sent < TOTAL_WORDS)
        begin
            t = pick_type();
            if (round == 0)
                set_config(TYPE_INT, 1'b1, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
            else
                set_config(t, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           pick_bound(), pick_bound());
            if (round % 3 == 0 || words_sent > TOTAL_WORDS - CALM_WORDS)
                idle_pct = 0;
            else
                idle_pct = $urandom_range(5, 35);
            if (round == 1)
            begin
                idle_pct = 0;
                stall_asks++;
                repeat (24) put_char(8'($urandom_range(0, 255)), 1'b1);
            end
            repeat ($urandom_range(4, 40))
            begin
                build_field(round == 0 ? TYPE_INT : t);
                send_buf();
            end
            round++;
        end

        push <= 1'b0;
        while (verdicts_pending != 0)
            @(negedge clk);
        repeat (4 * SETTLE) @(negedge clk);
        if (verdict_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
